// ===== rtl/core/nhqp_pkg.sv =====
// shared types, constants and codes of the nvme host queue pair engine
`timescale 1ns / 1ps
package nhqp_pkg;

  localparam int unsigned ADMIN_DEPTH = 16;
  localparam int unsigned IO_DEPTH    = 64;
  localparam int unsigned ADMIN_IW    = $clog2(ADMIN_DEPTH);
  localparam int unsigned IO_IW       = $clog2(IO_DEPTH);

  localparam logic [31:0] DB_BASE = 32'h0000_1000;

  localparam logic CMD_SUBMIT   = 1'b0;
  localparam logic CMD_COMPLETE = 1'b1;
  localparam logic QSEL_ADMIN   = 1'b0;
  localparam logic QSEL_IO      = 1'b1;

  localparam logic REG_STRIDE_EXP = 1'b0;
  localparam logic REG_IO_QID     = 1'b1;

  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 112;

  typedef enum logic [1:0] {
    OUT_NONE       = 2'd0,
    OUT_UNEXPECTED = 2'd1,
    OUT_SUCCESS    = 2'd2,
    OUT_DEV_ERROR  = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [3:0]  stride_exp;
    logic [15:0] io_qid;
  } cfg_t;

  typedef struct packed {
    logic        command;
    logic        queue_sel;
    logic [31:0] cmd_dword0;
    logic [15:0] cqe_status;
    logic [15:0] cqe_ident;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  sq_slot;
    logic [31:0] dword0_out;
    logic [15:0] ident_used;
    logic [31:0] doorbell_offset;
    logic [5:0]  doorbell_value;
    logic        doorbell_write;
    outcome_e    outcome;
    logic [2:0]  status_type;
    logic [7:0]  status_value;
  } result_t;

endpackage

// ===== rtl/core/nhqp_cfg_regs.sv =====
// apb configuration registers: doorbell stride exponent and i/o queue id
`timescale 1ns / 1ps
module nhqp_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output nhqp_pkg::cfg_t      cfg_o
);
  import nhqp_pkg::*;

  logic [3:0]  stride_exp_q, stride_exp_d;
  logic [15:0] io_qid_q, io_qid_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    stride_exp_d = stride_exp_q;
    io_qid_d     = io_qid_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_STRIDE_EXP: stride_exp_d = pwdata[3:0];
        REG_IO_QID:     io_qid_d     = pwdata[15:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_exp_q <= 4'd0;
      io_qid_q     <= 16'd1;
    end else begin
      stride_exp_q <= stride_exp_d;
      io_qid_q     <= io_qid_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STRIDE_EXP: prdata = {28'd0, stride_exp_q};
      REG_IO_QID:     prdata = {16'd0, io_qid_q};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o.stride_exp = stride_exp_q;
  assign cfg_o.io_qid     = io_qid_q;

endmodule

// ===== rtl/core/nhqp_core.sv =====
// queue indices, phase tags, identifiers and result logic of one item
`timescale 1ns / 1ps
module nhqp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nhqp_pkg::cfg_t      cfg_i,
  input  nhqp_pkg::in_item_t  item_i,
  input  logic                fire_i,
  output nhqp_pkg::result_t   res_o
);
  import nhqp_pkg::*;

  logic [ADMIN_IW-1:0] admin_tail_q, admin_tail_d, admin_head_q, admin_head_d;
  logic [IO_IW-1:0]    io_tail_q, io_tail_d, io_head_q, io_head_d;
  logic                admin_phase_q, admin_phase_d, io_phase_q, io_phase_d;
  logic [15:0]         ident_q, ident_d;
  logic [15:0]         pending_q [2];
  logic [15:0]         pending_d [2];

  logic [ADMIN_IW-1:0] admin_tail_nx, admin_head_nx;
  logic [IO_IW-1:0]    io_tail_nx, io_head_nx;
  logic                admin_head_wrap, io_head_wrap;
  logic                sel, cur_phase, phase_ok;
  logic [15:0]         qid;
  logic [7:0]          code;
  logic [5:0]          new_tail6, new_head6, slot6;

  function automatic logic [31:0] db_offset(input logic [3:0] exp_v, input logic [15:0] qid_v,
                                            input logic is_head);
    logic [31:0] idx;
    idx = {15'd0, qid_v, is_head};
    return DB_BASE + (idx << ({1'b0, exp_v} + 5'd2));
  endfunction

  // index bumps with wrap at queue depth
  assign admin_tail_nx   = (admin_tail_q == ADMIN_IW'(ADMIN_DEPTH - 1)) ? '0 : admin_tail_q + 1'b1;
  assign admin_head_wrap = (admin_head_q == ADMIN_IW'(ADMIN_DEPTH - 1));
  assign admin_head_nx   = admin_head_wrap ? '0 : admin_head_q + 1'b1;
  assign io_tail_nx      = (io_tail_q == IO_IW'(IO_DEPTH - 1)) ? '0 : io_tail_q + 1'b1;
  assign io_head_wrap    = (io_head_q == IO_IW'(IO_DEPTH - 1));
  assign io_head_nx      = io_head_wrap ? '0 : io_head_q + 1'b1;

  assign sel       = item_i.queue_sel;
  assign qid       = (sel == QSEL_IO) ? cfg_i.io_qid : 16'd0;
  assign cur_phase = (sel == QSEL_IO) ? io_phase_q : admin_phase_q;
  assign phase_ok  = (item_i.cqe_status[0] == cur_phase);
  assign code      = item_i.cqe_status[8:1];
  assign slot6     = (sel == QSEL_IO) ? 6'(32'(io_tail_q)) : 6'(32'(admin_tail_q));
  assign new_tail6 = (sel == QSEL_IO) ? 6'(32'(io_tail_nx)) : 6'(32'(admin_tail_nx));
  assign new_head6 = (sel == QSEL_IO) ? 6'(32'(io_head_nx)) : 6'(32'(admin_head_nx));

  always_comb begin
    admin_tail_d  = admin_tail_q;
    admin_head_d  = admin_head_q;
    admin_phase_d = admin_phase_q;
    io_tail_d     = io_tail_q;
    io_head_d     = io_head_q;
    io_phase_d    = io_phase_q;
    ident_d       = ident_q;
    pending_d     = pending_q;
    res_o         = '0;
    res_o.outcome = OUT_NONE;

    if (item_i.command == CMD_SUBMIT) begin
      res_o.sq_slot         = slot6;
      res_o.dword0_out      = {ident_q, item_i.cmd_dword0[15:0]};
      res_o.ident_used      = ident_q;
      res_o.doorbell_offset = db_offset(cfg_i.stride_exp, qid, 1'b0);
      res_o.doorbell_value  = new_tail6;
      res_o.doorbell_write  = 1'b1;
      if (fire_i) begin
        ident_d        = ident_q + 16'd1;
        pending_d[sel] = ident_q;
        if (sel == QSEL_IO) io_tail_d = io_tail_nx;
        else admin_tail_d = admin_tail_nx;
      end
    end else if (phase_ok) begin
      res_o.doorbell_offset = db_offset(cfg_i.stride_exp, qid, 1'b1);
      res_o.doorbell_value  = new_head6;
      res_o.doorbell_write  = 1'b1;
      res_o.status_type     = item_i.cqe_status[11:9];
      res_o.status_value    = code;
      if (item_i.cqe_ident != pending_q[sel]) res_o.outcome = OUT_UNEXPECTED;
      else if (code != 8'd0) res_o.outcome = OUT_DEV_ERROR;
      else res_o.outcome = OUT_SUCCESS;
      if (fire_i) begin
        if (sel == QSEL_IO) begin
          io_head_d  = io_head_nx;
          io_phase_d = io_phase_q ^ io_head_wrap;
        end else begin
          admin_head_d  = admin_head_nx;
          admin_phase_d = admin_phase_q ^ admin_head_wrap;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      admin_tail_q  <= '0;
      admin_head_q  <= '0;
      admin_phase_q <= 1'b1;
      io_tail_q     <= '0;
      io_head_q     <= '0;
      io_phase_q    <= 1'b1;
      ident_q       <= 16'd0;
      pending_q[0]  <= 16'd0;
      pending_q[1]  <= 16'd0;
    end else begin
      admin_tail_q  <= admin_tail_d;
      admin_head_q  <= admin_head_d;
      admin_phase_q <= admin_phase_d;
      io_tail_q     <= io_tail_d;
      io_head_q     <= io_head_d;
      io_phase_q    <= io_phase_d;
      ident_q       <= ident_d;
      pending_q     <= pending_d;
    end
  end

  a_ident_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.command == CMD_SUBMIT |=> ident_q == $past(ident_q) + 16'd1)
    else $error("identifier counter did not advance on a submit");

  a_admin_phase_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(admin_phase_q) |-> admin_head_q == '0)
    else $error("admin phase toggled without head wrap");

  a_io_phase_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(io_phase_q) |-> io_head_q == '0)
    else $error("i/o phase toggled without head wrap");

  a_consume_db: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.outcome != OUT_NONE |-> res_o.doorbell_write && item_i.command == CMD_COMPLETE)
    else $error("consumed entry without head doorbell");

endmodule

// ===== rtl/core/nvme_host_queue_pair_engine.sv =====
// top level: stream ports, input register, result register and configuration port
// path: a beat accepted on the slave side passes the input register, then the result register
// throughput: one beat per cycle while the master side does not stall
// a stalled master side holds the result; one more beat is still taken into the input register
// reset: asynchronous active low; indices cleared, phases set to one, identifiers zero
// reset also restores stride exponent zero and i/o queue id one
`timescale 1ns / 1ps
module nvme_host_queue_pair_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd_dword0[31:0], cqe_status[47:32], cqe_ident[63:48]
  input  logic [nhqp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // command[0], queue_sel[1]
  input  logic [nhqp_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // sq_slot[5:0], dword0_out[37:6], ident_used[53:38], doorbell_offset[85:54],
  // doorbell_value[91:86], doorbell_write[92], outcome[94:93], status_type[97:95],
  // status_value[105:98], zero fill up to bit 111
  output logic [nhqp_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import nhqp_pkg::*;

  cfg_t     cfg;
  in_item_t in_q, in_d;
  result_t  res_q, res_comb;
  logic     in_vld_q, in_vld_d, res_vld_q, res_vld_d;
  logic     adv, s_fire;

  nhqp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // item moves from input register to result register
  assign adv           = in_vld_q & (~res_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | adv;
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_d            = in_q;
    in_d.command    = s_axis_tuser[0];
    in_d.queue_sel  = s_axis_tuser[1];
    in_d.cmd_dword0 = s_axis_tdata[31:0];
    in_d.cqe_status = s_axis_tdata[47:32];
    in_d.cqe_ident  = s_axis_tdata[63:48];
    in_vld_d        = s_fire | (in_vld_q & ~adv);
    res_vld_d       = adv | (res_vld_q & ~m_axis_tready);
  end

  nhqp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (in_q),
    .fire_i (adv),
    .res_o  (res_comb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) in_q <= in_d;
    if (adv) res_q <= res_comb;
  end

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = {6'd0, res_q.status_value, res_q.status_type, res_q.outcome,
                          res_q.doorbell_write, res_q.doorbell_value, res_q.doorbell_offset,
                          res_q.ident_used, res_q.dword0_out, res_q.sq_slot};

endmodule
